// File: rtl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants of the CSV integer cell parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

  localparam int unsigned DEF_COORD_BITS = 16;
  localparam int unsigned OUT_COORD_BITS = 16;
  localparam int unsigned VALUE_BITS     = 32;

  localparam logic [7:0] DEF_COL_SEP = 8'd44;  // ','
  localparam logic [7:0] DEF_ROW_SEP = 8'd10;  // LF

  // configuration register map
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam logic        REG_COL_SEP   = 1'b0;
  localparam logic        REG_ROW_SEP   = 1'b1;

  // largest magnitude kept by the digit accumulator
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  typedef struct packed {
    logic [VALUE_BITS-1:0]     value;
    logic [OUT_COORD_BITS-1:0] row;
    logic [OUT_COORD_BITS-1:0] column;
    logic                      ends_row;
    logic                      final_cell;
  } csvp_res_t;

endpackage

`default_nettype wire

// File: rtl/csvp_cfg.sv
// ----------------------------------------------------------------------------
// csvp_cfg
// APB register file holding the column and row separator bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_cfg
  import csvp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output logic      [7:0]               col_sep,
  output logic      [7:0]               row_sep
);

  logic [7:0] col_sep_r;
  logic [7:0] row_sep_r;
  logic       reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_sep_r <= DEF_COL_SEP;
      row_sep_r <= DEF_ROW_SEP;
    end else if (wr_en) begin
      case (reg_sel)
        REG_COL_SEP: col_sep_r <= pwdata[7:0];
        REG_ROW_SEP: row_sep_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COL_SEP: prdata = {24'd0, col_sep_r};
      REG_ROW_SEP: prdata = {24'd0, row_sep_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign col_sep = col_sep_r;
  assign row_sep = row_sep_r;

endmodule

`default_nettype wire

// File: rtl/csvp_core.sv
// ----------------------------------------------------------------------------
// csvp_core
// Input register and single-pass field parser with cell coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_core
  import csvp_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eod,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] col_sep,
  input  wire logic [7:0] row_sep,
  input  wire logic       res_ready,
  output logic            res_valid,
  output csvp_res_t       res
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eod_r;

  // parse state
  logic [31:0]           acc_r,     acc_nxt;
  logic                  neg_r,     neg_nxt;
  phase_t                phase_r,   phase_nxt;
  logic                  pending_r, pending_nxt;
  logic [COORD_BITS-1:0] row_r,     row_nxt;
  logic [COORD_BITS-1:0] col_r,     col_nxt;

  logic        advance;
  logic        is_digit;
  logic        is_space;
  logic [35:0] acc_x10;
  logic [35:0] acc_dig;
  logic [31:0] acc_sat;
  logic [31:0] emit_value;

  assign advance  = s1_valid_r && res_ready;
  assign in_ready = !s1_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_eod_r  <= in_eod;
    end
  end

  assign is_digit = s1_byte_r inside {[8'h30:8'h39]};
  assign is_space = s1_byte_r inside {8'd32, [8'd9:8'd13]};

  // times ten as two shifts, then add the digit and clamp
  assign acc_x10 = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1);
  assign acc_dig = acc_x10 + {32'd0, s1_byte_r[3:0]};
  assign acc_sat = (acc_dig > MAG_LIMIT) ? MAG_LIMIT[31:0] : acc_dig[31:0];

  // magnitude never exceeds 2^31, so bit 31 alone flags positive overflow
  always_comb begin
    if (neg_r) begin
      emit_value = 32'd0 - acc_r;
    end else if (acc_r[31]) begin
      emit_value = 32'h7FFF_FFFF;
    end else begin
      emit_value = acc_r;
    end
  end

  always_comb begin
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    res_valid      = 1'b0;
    res.value      = emit_value;
    res.row        = OUT_COORD_BITS'(row_r);
    res.column     = OUT_COORD_BITS'(col_r);
    res.ends_row   = 1'b0;
    res.final_cell = 1'b0;
    if (advance) begin
      if (s1_eod_r) begin
        res_valid      = pending_r;
        res.final_cell = 1'b1;
        acc_nxt        = 32'd0;
        neg_nxt        = 1'b0;
        phase_nxt      = PH_SKIP;
        pending_nxt    = 1'b0;
        row_nxt        = '0;
        col_nxt        = '0;
      end else if (s1_byte_r == row_sep) begin
        res_valid    = 1'b1;
        res.ends_row = 1'b1;
        acc_nxt      = 32'd0;
        neg_nxt      = 1'b0;
        phase_nxt    = PH_SKIP;
        pending_nxt  = 1'b0;
        col_nxt      = '0;
        row_nxt      = row_r + 1'b1;
      end else if (s1_byte_r == col_sep) begin
        res_valid   = 1'b1;
        acc_nxt     = 32'd0;
        neg_nxt     = 1'b0;
        phase_nxt   = PH_SKIP;
        pending_nxt = 1'b0;
        col_nxt     = col_r + 1'b1;
      end else begin
        pending_nxt = 1'b1;
        case (phase_r)
          PH_SKIP: begin
            if (is_space) begin
              phase_nxt = PH_SKIP;
            end else if (s1_byte_r == "+" || s1_byte_r == "-") begin
              neg_nxt   = (s1_byte_r == "-");
              phase_nxt = PH_DIGITS;
            end else if (is_digit) begin
              acc_nxt   = acc_sat;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOPPED;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_sat;
            end else begin
              phase_nxt = PH_STOPPED;
            end
          end
          default: ;  // stopped: ignore until the field ends
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 32'd0;
      neg_r     <= 1'b0;
      phase_r   <= PH_SKIP;
      pending_r <= 1'b0;
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/csvp_out_buf.sv
// ----------------------------------------------------------------------------
// csvp_out_buf
// Result register with a skid stage so out_tready never reaches upstream
// combinationally; upstream waits only while the skid word is held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_out_buf
  import csvp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire csvp_res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output csvp_res_t      out_data
);

  logic      out_valid_r;
  csvp_res_t out_data_r;
  logic      skid_valid_r;
  csvp_res_t skid_data_r;
  logic      out_free;

  assign push_ready = !skid_valid_r;
  assign out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // drain the skid word first to keep order
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= skid_valid_r && push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r  <= skid_valid_r ? skid_data_r : push_data;
      skid_data_r <= push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/csv_integer_cell_parser.sv
// ----------------------------------------------------------------------------
// csv_integer_cell_parser
// CSV text to signed integer cells, one text byte per word.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the in_ stream and emits a cell on the out_
// stream at each column or row separator, and at in_tlast when a field is
// pending. Sustained rate is one byte per cycle while no skid word is held;
// a cell passes the input register, then the result register, to out_.
// The multiply-by-ten and add of the digit accumulator set the cycle time.
// Separators are set through the cfg_ APB port: column separator at address
// 0, row separator at address 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csv_integer_cell_parser
  import csvp_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [7:0]               in_tdata,   // [7:0] text_byte
  input  wire logic                     in_tlast,   // end_of_data
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [63:0]              out_tdata,  // [31:0] cell_value,
                                                    // [47:32] cell_row,
                                                    // [63:48] cell_column
  output logic                          out_tlast,  // ends_row
  output logic                          out_tuser,  // final_cell
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  output logic      [31:0]              cfg_prdata,
  output logic                          cfg_pready
);

  logic [7:0] col_sep;
  logic [7:0] row_sep;
  logic       res_valid;
  logic       res_ready;
  csvp_res_t  res;
  csvp_res_t  out_res;

  csvp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .col_sep (col_sep),
    .row_sep (row_sep)
  );

  csvp_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .in_eod    (in_tlast),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .col_sep   (col_sep),
    .row_sep   (row_sep),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  csvp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.column, out_res.row, out_res.value};
  assign out_tlast = out_res.ends_row;
  assign out_tuser = out_res.final_cell;

endmodule

`default_nettype wire

// File: tb/csvp_checker.sv
// ----------------------------------------------------------------------------
// csvp_checker
// Cell predictor and scoreboard for the CSV integer cell parser.
// ----------------------------------------------------------------------------
// Snoops the in_ and out_ streams and the cfg_ write port. Every text word
// taken by the parser runs through a local copy of the field parser; any cell
// it yields is queued and compared field by field against the next cell word
// on the out_ stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvp_checker
  import csvp_pkg::*;
#(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  input  wire logic                     in_tready,
  input  wire logic [7:0]               in_tdata,
  input  wire logic                     in_tlast,
  input  wire logic                     out_tvalid,
  input  wire logic                     out_tready,
  input  wire logic [63:0]              out_tdata,
  input  wire logic                     out_tlast,
  input  wire logic                     out_tuser,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  input  wire logic                     cfg_pready,
  output int unsigned                   mismatches,
  output int unsigned                   cells_waiting
);

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } parse_phase_t;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  logic [7:0]            col_sep;
  logic [7:0]            row_sep;
  logic [31:0]           mag;
  logic                  neg;
  logic                  pending;
  parse_phase_t          phase;
  logic [COORD_BITS-1:0] row_idx;
  logic [COORD_BITS-1:0] col_idx;
  csvp_res_t             cell_q[$];
  int unsigned           fail_cnt = 0;

  assign mismatches = fail_cnt;

  function automatic csvp_res_t make_cell(input logic ends, input logic fin);
    csvp_res_t c;
    if (neg) begin
      c.value = 32'd0 - mag;
    end else begin
      c.value = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    end
    c.row        = OUT_COORD_BITS'(row_idx);
    c.column     = OUT_COORD_BITS'(col_idx);
    c.ends_row   = ends;
    c.final_cell = fin;
    return c;
  endfunction

  function automatic void clear_field();
    mag     = '0;
    neg     = 1'b0;
    phase   = PH_SKIP;
    pending = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] b);
    logic [35:0] m;
    m   = 36'(mag) * 36'd10 + 36'(b - CH_ZERO);
    mag = (m > MAG_LIMIT) ? MAG_LIMIT[31:0] : m[31:0];
  endfunction

  function automatic void parse_word(input logic [7:0] b, input logic eod);
    logic is_digit;
    logic is_space;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    if (eod) begin
      if (pending) cell_q.push_back(make_cell(1'b0, 1'b1));
      clear_field();
      row_idx = '0;
      col_idx = '0;
    end else if (b == row_sep) begin
      // row separator wins when both separators match
      cell_q.push_back(make_cell(1'b1, 1'b0));
      clear_field();
      col_idx = '0;
      row_idx = row_idx + 1'b1;
    end else if (b == col_sep) begin
      cell_q.push_back(make_cell(1'b0, 1'b0));
      clear_field();
      col_idx = col_idx + 1'b1;
    end else begin
      pending = 1'b1;
      case (phase)
        PH_SKIP: begin
          if (is_space) begin
            // hold in skip
          end else if (b == CH_PLUS || b == CH_MINUS) begin
            neg   = (b == CH_MINUS);
            phase = PH_DIGITS;
          end else if (is_digit) begin
            add_digit(b);
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOPPED;
          end
        end
        PH_DIGITS: begin
          if (is_digit) add_digit(b);
          else phase = PH_STOPPED;
        end
        default: ;
      endcase
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    csvp_res_t want;
    if (!rst_n) begin
      col_sep = DEF_COL_SEP;
      row_sep = DEF_ROW_SEP;
      clear_field();
      row_idx = '0;
      col_idx = '0;
      cell_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[1:0] == 2'b00) begin
        case (cfg_paddr[2])
          REG_COL_SEP: col_sep = cfg_pwdata[7:0];
          REG_ROW_SEP: row_sep = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (cell_q.size() == 0) begin
          $error("cell word with no cell expected: tdata 0x%016h", out_tdata);
          fail_cnt++;
        end else begin
          want = cell_q.pop_front();
          check_field("cell_value", want.value, out_tdata[31:0]);
          check_field("cell_row", 32'(want.row), 32'(out_tdata[47:32]));
          check_field("cell_column", 32'(want.column), 32'(out_tdata[63:48]));
          check_field("ends_row", 32'(want.ends_row), 32'(out_tlast));
          check_field("final_cell", 32'(want.final_cell), 32'(out_tuser));
        end
      end
      if (in_tvalid && in_tready) parse_word(in_tdata, in_tlast);
    end
    cells_waiting <= cell_q.size();
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the CSV integer cell parser.
// ----------------------------------------------------------------------------
// Feeds CSV text to the parser: a short directed run over the corner cases,
// then random records under several separator settings (defaults, extremes,
// whitespace and equal separators), and last a short record flushed by end
// of data. Input bursts, gaps and output stalls are random; csvp_checker
// does the prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import csvp_pkg::*;

  localparam int unsigned TEXT_BYTES    = 1550;
  localparam int unsigned PHASE_BYTES   = 220;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_PIPE  = 8'd124;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata = '0;   // [7:0] text_byte
  logic                     in_tlast = 1'b0; // end_of_data
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [63:0]              out_tdata;       // [31:0] value, [47:32] row, [63:48] column
  logic                     out_tlast;       // ends_row
  logic                     out_tuser;       // final_cell
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0]              cfg_pwdata = '0;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  int unsigned mismatches;
  int unsigned cells_waiting;

  logic [7:0]  cur_col_sep = DEF_COL_SEP;
  logic [7:0]  cur_row_sep = DEF_ROW_SEP;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic        steady = 1'b0;
  logic [15:0] rx_tick = '0;

  csv_integer_cell_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  csvp_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .mismatches    (mismatches),
    .cells_waiting (cells_waiting)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stall pattern: always ready, coin flip, stall when rx_tick is divisible by three, light stalls
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    case (rx_tick[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 0);
      2'd2: out_tready <= (rx_tick % 3 != 0);
      default: out_tready <= ($urandom_range(0, 5) != 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // drop valid and hold until every cell is out and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (cells_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_separators(input logic [7:0] col, input logic [7:0] row);
    drain();
    write_reg(REG_COL_SEP, col);
    write_reg(REG_ROW_SEP, row);
    cur_col_sep = col;
    cur_row_sep = row;
  endtask

  function automatic logic [7:0] pick_space();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // one field followed by its terminator
  task automatic send_record();
    int unsigned kind;
    int unsigned n;
    int unsigned sel;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(0, 2)) send_byte(pick_space(), 1'b0);
      case ($urandom_range(0, 3))
        0: send_byte(CH_MINUS, 1'b0);
        1: send_byte(CH_PLUS, 1'b0);
        default: ;
      endcase
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
      repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 3)) send_byte(pick_space(), 1'b0);
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (kind == 9) begin
      send_byte(($urandom_range(0, 1) == 0) ? CH_MINUS : CH_PLUS, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      send_byte(cur_col_sep, 1'b0);
    end else if (sel < 93) begin
      send_byte(cur_row_sep, 1'b0);
      // trailing separator: end of data with nothing pending
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned goal;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty field, whitespace and sign, stopped field, saturation,
    // flush of a pending field, end of data with nothing pending
    send_text(",");
    send_text(" -7\n");
    send_text("+x9,");
    send_text("-99999999999,");
    send_byte("5", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    phase_no = 0;
    while (bytes_sent < TEXT_BYTES) begin
      case (phase_no)
        0: ;
        1: set_separators(8'd0, 8'd255);
        2: set_separators(8'd255, 8'd0);
        3: set_separators(CH_SPACE, CH_TAB);
        4: set_separators(CH_SEMI, CH_SEMI);
        5: set_separators(CH_PIPE, CH_CR);
        default: set_separators(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal && bytes_sent < TEXT_BYTES) send_record();
      phase_no++;
    end

    // flush a pending field under the default separators
    set_separators(DEF_COL_SEP, DEF_ROW_SEP);
    send_text("-3,4");
    send_byte(8'h00, 1'b1);

    drain();
    if (mismatches == 0 && cells_waiting == 0) begin
      $display("** csv_integer_cell_parser: PASSED **");
    end else begin
      $display("** csv_integer_cell_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("** csv_integer_cell_parser: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
